// ===== rtl/nkro_pkg.sv =====
// ---------------------------------------------------------------------------
// nkro_pkg: shared types and constants for the NKRO report builder
// Word layouts of the request and response channels, sequencer states
// and the control group between the sequencer and the entry table.
// ---------------------------------------------------------------------------
`default_nettype none

package nkro_pkg;

   localparam int NumOutputsDef = 32;
   localparam int KeyLimit      = 120;
   localparam int KeyLowW       = 64;
   localparam int KeyHighW      = KeyLimit - KeyLowW;

   localparam logic CMD_PRESS   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] output_index;
      logic [7:0] modifier_in;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [7:0]          modifier_byte;
      logic [KeyLowW-1:0]  keys_low;
      logic [KeyHighW-1:0] keys_high;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic wr_en;     // update entry at write address
      logic held_set;  // 1: press (store and hold), 0: release (clear)
      logic rd_en;     // read entry at scan address
   } tbl_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/nkro_table.sv =====
// ---------------------------------------------------------------------------
// nkro_table: per-output entry store
// Modifier and key memory with one write and one registered read port,
// plus the held-bit vector.
// ---------------------------------------------------------------------------
`default_nettype none

module nkro_table #(
   parameter int NUM_OUTPUTS = nkro_pkg::NumOutputsDef,
   localparam int IdxW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  nkro_pkg::tbl_ctrl_type   ctrl,
   input  wire  [IdxW-1:0]          wr_addr,
   input  wire  [7:0]               wr_mod,
   input  wire  [7:0]               wr_key,
   input  wire  [IdxW-1:0]          rd_addr,
   output logic [NUM_OUTPUTS-1:0]   held_mask,
   output logic                     rd_valid,
   output logic                     rd_held,
   output logic [7:0]               rd_mod,
   output logic [7:0]               rd_key
);

   logic [7:0] mod_mem [NUM_OUTPUTS];
   logic [7:0] key_mem [NUM_OUTPUTS];

   logic [NUM_OUTPUTS-1:0] held_mask_ff, held_mask_in;
   logic                   rd_valid_ff;
   logic                   rd_held_ff;
   logic [7:0]             rd_mod_ff;
   logic [7:0]             rd_key_ff;

   always_comb begin
      held_mask_in = held_mask_ff;
      if (ctrl.wr_en) begin
         held_mask_in[wr_addr] = ctrl.held_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mask_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         held_mask_ff <= held_mask_in;
         rd_valid_ff  <= ctrl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mod_mem[wr_addr] <= ctrl.held_set ? wr_mod : 8'h00;
         key_mem[wr_addr] <= ctrl.held_set ? wr_key : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_mod_ff  <= mod_mem[rd_addr];
         rd_key_ff  <= key_mem[rd_addr];
         rd_held_ff <= held_mask_ff[rd_addr];
      end
   end

   assign held_mask = held_mask_ff;
   assign rd_valid  = rd_valid_ff;
   assign rd_held   = rd_held_ff;
   assign rd_mod    = rd_mod_ff;
   assign rd_key    = rd_key_ff;

endmodule

`default_nettype wire

// ===== rtl/nkro_accum.sv =====
// ---------------------------------------------------------------------------
// nkro_accum: report accumulator
// Folds one table entry per cycle into the modifier byte and key bitmap.
// ---------------------------------------------------------------------------
`default_nettype none

module nkro_accum (
   input  wire                clock,
   input  wire                clear,
   input  wire                en,
   input  wire                held,
   input  wire  [7:0]         mod,
   input  wire  [7:0]         key,
   output nkro_pkg::rsp_type  report
);

   localparam int KeyLimit = nkro_pkg::KeyLimit;

   logic [7:0]          mod_ff, mod_in;
   logic [KeyLimit-1:0] keys_ff, keys_in;
   logic [KeyLimit-1:0] key_onehot;
   logic                key_ok;

   always_comb begin
      key_ok     = (key != 8'h00) && (key < 8'(KeyLimit));
      key_onehot = '0;
      if (key_ok) begin
         key_onehot[key[6:0]] = 1'b1;
      end
   end

   always_comb begin
      mod_in  = mod_ff;
      keys_in = keys_ff;
      if (clear) begin
         mod_in  = 8'h00;
         keys_in = '0;
      end else if (en && held) begin
         mod_in  = mod_ff | mod;
         keys_in = keys_ff | key_onehot;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff  <= mod_in;
      keys_ff <= keys_in;
   end

   assign report.modifier_byte = mod_ff;
   assign report.keys_low      = keys_ff[nkro_pkg::KeyLowW-1:0];
   assign report.keys_high     = keys_ff[KeyLimit-1:nkro_pkg::KeyLowW];

endmodule

`default_nettype wire

// ===== rtl/nkro_ctrl.sv =====
// ---------------------------------------------------------------------------
// nkro_ctrl: event sequencer
// Captures one event; on a hit updates the table, scans every entry through
// the accumulator and hands the finished report to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nkro_ctrl #(
   parameter int NUM_OUTPUTS = nkro_pkg::NumOutputsDef,
   localparam int IdxW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  nkro_pkg::req_type          req_data,
   input  wire  [NUM_OUTPUTS-1:0]     held_mask,
   input  wire                        out_free,
   output nkro_pkg::tbl_ctrl_type     tbl_ctrl,
   output logic [IdxW-1:0]            wr_addr,
   output logic [7:0]                 wr_mod,
   output logic [7:0]                 wr_key,
   output logic [IdxW-1:0]            rd_addr,
   output logic                       acc_clear,
   output logic                       load_out
);

   nkro_pkg::state_type state_ff, state_in;
   nkro_pkg::req_type   req_ff, req_in;
   logic [IdxW-1:0]     cnt_ff, cnt_in;

   logic in_range;
   logic hit;
   logic scan_last;

   assign in_range  = req_ff.output_index < 8'(NUM_OUTPUTS);
   assign hit       = in_range &&
                      ((req_ff.cmd == nkro_pkg::CMD_PRESS) ||
                       held_mask[req_ff.output_index[IdxW-1:0]]);
   assign scan_last = (cnt_ff == IdxW'(NUM_OUTPUTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nkro_pkg::ST_IDLE: begin
            if (req_valid) state_in = nkro_pkg::ST_CHECK;
         end
         nkro_pkg::ST_CHECK: begin
            state_in = hit ? nkro_pkg::ST_SCAN : nkro_pkg::ST_IDLE;
         end
         nkro_pkg::ST_SCAN: begin
            if (scan_last) state_in = nkro_pkg::ST_DRAIN;
         end
         nkro_pkg::ST_DRAIN: begin
            state_in = nkro_pkg::ST_OUT;
         end
         nkro_pkg::ST_OUT: begin
            if (out_free) state_in = nkro_pkg::ST_IDLE;
         end
         default: state_in = nkro_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = 1'b0;
      tbl_ctrl.wr_en    = 1'b0;
      tbl_ctrl.held_set = (req_ff.cmd == nkro_pkg::CMD_PRESS);
      tbl_ctrl.rd_en    = 1'b0;
      acc_clear         = 1'b0;
      load_out          = 1'b0;
      req_in            = req_ff;
      cnt_in            = cnt_ff;
      unique case (state_ff)
         nkro_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            req_in    = req_data;
         end
         nkro_pkg::ST_CHECK: begin
            tbl_ctrl.wr_en = hit;
            acc_clear      = 1'b1;
            cnt_in         = '0;
         end
         nkro_pkg::ST_SCAN: begin
            tbl_ctrl.rd_en = 1'b1;
            cnt_in         = cnt_ff + IdxW'(1);
         end
         nkro_pkg::ST_DRAIN: begin
         end
         nkro_pkg::ST_OUT: begin
            load_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nkro_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign wr_addr = req_ff.output_index[IdxW-1:0];
   assign wr_mod  = req_ff.modifier_in;
   assign wr_key  = req_ff.key_code;
   assign rd_addr = cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/nkro_report_builder.sv =====
// ---------------------------------------------------------------------------
// nkro_report_builder: N-key-rollover keyboard report builder
// Keeps a table of logical outputs and rebuilds the full report on every
// accepted in-range press or effective release.
// ---------------------------------------------------------------------------
// req_* carries one press/release word per handshake. A press of an
//   in-range output stores its modifier and key and emits a report; a
//   release of a held output clears it and emits a report. Out-of-range
//   indexes and releases of idle outputs emit nothing.
// rsp_* carries one report word: OR of held modifiers and a 120-bit key
//   bitmap split into keys_low and keys_high.
// Each accepted word is registered and checked; a hit writes the table,
//   then the scan reads one table entry per cycle into the shared
//   accumulator and the report is loaded into the output register.
//   req_ready is high only while the sequencer is idle, so no new word is
//   taken before the last one is through.
// A stalled report waits in the output register while the next word is
//   scanned; the sequencer holds the new report until the register frees.
// Reset empties the table (nothing held) and drops any pending report.
// ---------------------------------------------------------------------------
`default_nettype none

module nkro_report_builder #(
   parameter int NUM_OUTPUTS = nkro_pkg::NumOutputsDef
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  nkro_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output nkro_pkg::rsp_type   rsp_data
);

   localparam int IdxW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

   nkro_pkg::tbl_ctrl_type tbl_ctrl;
   nkro_pkg::rsp_type      report;
   logic [IdxW-1:0]        wr_addr;
   logic [IdxW-1:0]        rd_addr;
   logic [7:0]             wr_mod;
   logic [7:0]             wr_key;
   logic [NUM_OUTPUTS-1:0] held_mask;
   logic                   rd_valid;
   logic                   rd_held;
   logic [7:0]             rd_mod;
   logic [7:0]             rd_key;
   logic                   acc_clear;
   logic                   load_out;
   logic                   out_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   nkro_pkg::rsp_type      rsp_data_ff;

   nkro_ctrl #(
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .held_mask (held_mask),
      .out_free  (out_free),
      .tbl_ctrl  (tbl_ctrl),
      .wr_addr   (wr_addr),
      .wr_mod    (wr_mod),
      .wr_key    (wr_key),
      .rd_addr   (rd_addr),
      .acc_clear (acc_clear),
      .load_out  (load_out)
   );

   nkro_table #(
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tbl_ctrl),
      .wr_addr   (wr_addr),
      .wr_mod    (wr_mod),
      .wr_key    (wr_key),
      .rd_addr   (rd_addr),
      .held_mask (held_mask),
      .rd_valid  (rd_valid),
      .rd_held   (rd_held),
      .rd_mod    (rd_mod),
      .rd_key    (rd_key)
   );

   nkro_accum u_accum (
      .clock  (clock),
      .clear  (acc_clear),
      .en     (rd_valid),
      .held   (rd_held),
      .mod    (rd_mod),
      .key    (rd_key),
      .report (report)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= report;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== bench/nkro_report_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nkro_report_checker: report prediction and comparison for the NKRO builder
// Watches both channels. Each accepted in-range press or release of a held
// output updates a private copy of the output table and queues the rebuilt
// report. Each accepted report word is compared with the oldest queued one.
// ---------------------------------------------------------------------------

module nkro_report_checker #(
   parameter int NUM_OUTPUTS = nkro_pkg::NumOutputsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  nkro_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  nkro_pkg::rsp_type rsp_data,
   output int                pending,
   output int                errors
);

   logic [7:0]             slot_modifier [NUM_OUTPUTS];
   logic [7:0]             slot_key      [NUM_OUTPUTS];
   logic [NUM_OUTPUTS-1:0] slot_held;
   nkro_pkg::rsp_type      expected_reports [$];
   nkro_pkg::rsp_type      want;
   int                     fail_total = 0;

   function automatic nkro_pkg::rsp_type rebuild_report();
      nkro_pkg::rsp_type r;
      int                k;
      r = '0;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         if (slot_held[i]) begin
            r.modifier_byte = r.modifier_byte | slot_modifier[i];
            k = slot_key[i];
            if (k != 0 && k < nkro_pkg::KeyLimit) begin
               if (k < nkro_pkg::KeyLowW)
                  r.keys_low[k] = 1'b1;
               else
                  r.keys_high[k - nkro_pkg::KeyLowW] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // apply one key event; queue a report for an in-range press or a held release
   task automatic apply_key_event(input nkro_pkg::req_type w);
      int idx;
      idx = w.output_index;
      if (idx < NUM_OUTPUTS) begin
         if (w.cmd == nkro_pkg::CMD_PRESS) begin
            slot_modifier[idx] = w.modifier_in;
            slot_key[idx]      = w.key_code;
            slot_held[idx]     = 1'b1;
            expected_reports.push_back(rebuild_report());
         end else if (slot_held[idx]) begin
            slot_modifier[idx] = '0;
            slot_key[idx]      = '0;
            slot_held[idx]     = 1'b0;
            expected_reports.push_back(rebuild_report());
         end
      end
   endtask

   task automatic note_mismatch(input string field, input logic [63:0] exp_val,
                                input logic [63:0] act_val);
      fail_total++;
      if (fail_total <= 30)
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            slot_modifier[i] = '0;
            slot_key[i]      = '0;
         end
         slot_held = '0;
         expected_reports.delete();
         pending <= 0;
      end else begin
         // compare before applying the event of this edge: its report is far off
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               fail_total++;
               if (fail_total <= 30)
                  $display("%0t: report word with none expected: mod %h low %h high %h",
                           $time, rsp_data.modifier_byte, rsp_data.keys_low,
                           rsp_data.keys_high);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.modifier_byte !== want.modifier_byte)
                  note_mismatch("modifier_byte", 64'(want.modifier_byte),
                                64'(rsp_data.modifier_byte));
               if (rsp_data.keys_low !== want.keys_low)
                  note_mismatch("keys_low", want.keys_low, rsp_data.keys_low);
               if (rsp_data.keys_high !== want.keys_high)
                  note_mismatch("keys_high", 64'(want.keys_high), 64'(rsp_data.keys_high));
            end
         end
         if (req_valid && req_ready)
            apply_key_event(req_data);
         pending <= expected_reports.size();
      end
      errors <= fail_total;
   end

endmodule

// ===== bench/tb_nkro_report_builder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nkro_report_builder: stimulus and verdict for the NKRO report builder
// Drives directed press/release words over the table edges and key limits,
// then random key event sequences with bursty input and a stalling receiver.
// The checker beside the block predicts and compares every report word.
// ---------------------------------------------------------------------------

module tb_nkro_report_builder;

   localparam int NUM_OUTPUTS  = nkro_pkg::NumOutputsDef;
   localparam int RANDOM_WORDS = 750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   nkro_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   nkro_pkg::rsp_type rsp_data;

   int                     pending;
   int                     fail_count;
   int                     cycle_count  = 0;
   int                     reports_seen = 0;
   logic [NUM_OUTPUTS-1:0] pressed_map  = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nkro_report_builder #(
      .NUM_OUTPUTS(NUM_OUTPUTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   nkro_report_checker #(
      .NUM_OUTPUTS(NUM_OUTPUTS)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .pending   (pending),
      .errors    (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_valid && rsp_ready)
         reports_seen <= reports_seen + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** nkro_report_builder: FAILED **");
         $finish;
      end
   end

   task automatic send_word(input logic cmd, input logic [7:0] idx,
                            input logic [7:0] mod, input logic [7:0] key);
      nkro_pkg::req_type w;
      w.cmd          = cmd;
      w.output_index = idx;
      w.modifier_in  = mod;
      w.key_code     = key;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (idx < NUM_OUTPUTS)
         pressed_map[idx] = (cmd == nkro_pkg::CMD_PRESS);
   endtask

   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
   endtask

   // mostly in-range events; releases favor outputs that are held
   task automatic send_random_event();
      logic       cmd;
      logic [7:0] idx;
      logic [7:0] mod;
      logic [7:0] key;
      if ($urandom_range(0, 99) < 8)
         idx = 8'($urandom_range(NUM_OUTPUTS, 255));
      else
         idx = 8'($urandom_range(0, NUM_OUTPUTS - 1));
      cmd = ($urandom_range(0, 99) < 52) ? nkro_pkg::CMD_PRESS : nkro_pkg::CMD_RELEASE;
      if (cmd == nkro_pkg::CMD_RELEASE && idx < NUM_OUTPUTS && pressed_map != '0
          && $urandom_range(0, 3) != 0) begin
         do
            idx = 8'($urandom_range(0, NUM_OUTPUTS - 1));
         while (!pressed_map[idx]);
      end
      case ($urandom_range(0, 3))
         0:       mod = 8'h01 << $urandom_range(0, 7);
         1:       mod = '0;
         default: mod = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 99) < 75)
         key = 8'($urandom_range(1, nkro_pkg::KeyLimit - 1));
      else
         key = 8'($urandom_range(0, 255));
      send_word(cmd, idx, mod, key);
   endtask

   // receiver: stall pattern changes after each random span, one long hold-off
   initial begin
      int mode;
      int span;
      bit held_off;
      held_off = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (!held_off && reports_seen >= 120) begin
               held_off = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES)
                  @(negedge clock);
            end else begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 4) == 0);
                  default: rsp_ready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   initial begin
      int burst_left;
      burst_left = 0;
      repeat (8)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table edges, key limits, overwrite and ignored events
      send_word(nkro_pkg::CMD_PRESS,   8'd0,   8'hFF, 8'd1);
      send_word(nkro_pkg::CMD_PRESS,   8'd31,  8'h00, 8'd119);
      send_word(nkro_pkg::CMD_PRESS,   8'd5,   8'h80, 8'd63);
      send_word(nkro_pkg::CMD_PRESS,   8'd6,   8'h01, 8'd64);
      send_word(nkro_pkg::CMD_PRESS,   8'd7,   8'h55, 8'd0);
      send_word(nkro_pkg::CMD_PRESS,   8'd8,   8'hAA, 8'd120);
      send_word(nkro_pkg::CMD_PRESS,   8'd9,   8'h00, 8'd255);
      send_word(nkro_pkg::CMD_PRESS,   8'd10,  8'h10, 8'd64);
      send_word(nkro_pkg::CMD_PRESS,   8'd5,   8'h02, 8'd100);
      send_word(nkro_pkg::CMD_RELEASE, 8'd12,  8'hFF, 8'hFF);
      send_word(nkro_pkg::CMD_RELEASE, 8'd5,   8'hFF, 8'hFF);
      send_word(nkro_pkg::CMD_PRESS,   8'd32,  8'hFF, 8'd1);
      send_word(nkro_pkg::CMD_PRESS,   8'd255, 8'hFF, 8'd255);
      send_word(nkro_pkg::CMD_RELEASE, 8'd128, 8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd31,  8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd0,   8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd6,   8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd7,   8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd8,   8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd10,  8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd9,   8'h00, 8'd0);
      send_word(nkro_pkg::CMD_PRESS,   8'd16,  8'h00, 8'd0);
      send_word(nkro_pkg::CMD_RELEASE, 8'd16,  8'h00, 8'd0);
      wait_drained();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2)
            wait_drained();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
               idle_for($urandom_range(1, 12));
         end
         send_random_event();
         burst_left--;
      end

      wait_drained();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (fail_count == 0)
         $display("** nkro_report_builder: PASSED **");
      else
         $display("** nkro_report_builder: FAILED **");
      $finish;
   end

endmodule
